// ===== rtl/core/leb_pkg.sv =====
// Shared constants and types for the line edit buffer.
// No dependencies; imported by leb_stack_mem and line_edit_buffer_top.
package leb_pkg;

    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 10;
    localparam int CNT_OUT_W   = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h2D;
    localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'h3C;
    localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'h3E;

    typedef enum logic {
        CMD_KEY  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic {
        STK_LEFT  = 1'b0,
        STK_RIGHT = 1'b1
    } stack_sel_t;

endpackage

// ===== rtl/core/leb_stack_mem.sv =====
// One character stack of the gap buffer: simple dual-port RAM with
// registered read data. Depends on leb_pkg for the character width.
module leb_stack_mem
    import leb_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    // Read returns the old contents on a same-address write; the caller forwards.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/line_edit_buffer_top.sv =====
// Line edit buffer: keystroke stream in, one status/read result per item out.
// Depends on leb_pkg and leb_stack_mem (two instances, left and right stack).
//
// Usage:
//   s_axis carries one transaction per item: tuser selects keystroke (0) or
//   read (1); tdata holds the key byte and the read index. '-' deletes the
//   character before the cursor, '<' and '>' move the cursor, any other byte
//   is inserted. m_axis returns one transaction per item with the read
//   character, the line length, the cursor and an overflow flag for a
//   dropped insert; tuser flags a read that hit a character.
//   Results pass the stage register, then the output register. Throughput is one
//   item per cycle while m_axis is ready: a cursor move reads one stack RAM and
//   writes the other as it leaves the stage register; a same-entry read-after-write is forwarded.
//   Reset empties the line (both counts zero); stack contents are not cleared
//   and need no clearing pass. When the receiver stalls, the output register
//   holds, then the stage register fills, then s_axis_tready drops.
module line_edit_buffer_top
    import leb_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key[7:0], read_index[17:8], zero
    input  logic                   s_axis_tuser,  // cmd[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // read_char[7:0], line_length[18:8],
                                                  // cursor_pos[29:19], overflow[30], zero
    output logic                   m_axis_tuser   // read_valid[0]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;

    // Input decode
    logic              in_accept;
    cmd_t              cmd;
    logic [CHAR_W-1:0] key;
    logic [IDX_W-1:0]  read_index;

    // Counts
    logic [CW-1:0] left_count_reg, left_count_next;
    logic [CW-1:0] right_count_reg, right_count_next;

    // Per-item decode
    logic [XW-1:0] len_x, idx_x, rpos_x;
    logic [CW-1:0] left_m1, right_m1;
    logic          full;
    logic          rd_en_next;
    stack_sel_t    rd_sel_next;
    logic [AW-1:0] rd_addr_next;
    logic          wr_en_next;
    stack_sel_t    wr_sel_next;
    logic [AW-1:0] wr_addr_next;
    logic          wr_from_key_next;
    logic          read_valid_next;
    logic          ovf_next;
    logic          fwd_hit_next;
    logic [XW-1:0] len_after;

    // Stage register
    logic                 s1_valid_reg, s1_valid_next;
    stack_sel_t           s1_rd_sel_reg;
    logic                 s1_fwd_hit_reg;
    logic [CHAR_W-1:0]    s1_fwd_data_reg;
    logic                 s1_wr_en_reg;
    stack_sel_t           s1_wr_sel_reg;
    logic [AW-1:0]        s1_wr_addr_reg;
    logic                 s1_wr_from_key_reg;
    logic [CHAR_W-1:0]    s1_key_reg;
    logic                 s1_read_valid_reg;
    logic                 s1_ovf_reg;
    logic [CNT_OUT_W-1:0] s1_len_reg;
    logic [CNT_OUT_W-1:0] s1_cur_reg;
    logic                 s1_adv;
    logic                 wr_fire;
    logic [CHAR_W-1:0]    s1_rd_data;
    logic [CHAR_W-1:0]    s1_wr_data;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_rvalid_reg;
    logic [CNT_OUT_W-1:0] out_len_reg;
    logic [CNT_OUT_W-1:0] out_cur_reg;
    logic                 out_ovf_reg;

    // RAM ports
    logic [CHAR_W-1:0] left_rd_data, right_rd_data;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign cmd        = cmd_t'(s_axis_tuser);
    assign key        = s_axis_tdata[CHAR_W-1:0];
    assign read_index = s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W];

    assign len_x    = XW'(left_count_reg) + XW'(right_count_reg);
    assign idx_x    = XW'(read_index);
    assign rpos_x   = len_x - idx_x - XW'(1);
    assign left_m1  = left_count_reg - CW'(1);
    assign right_m1 = right_count_reg - CW'(1);
    assign full     = len_x >= XW'(CAPACITY);

    always_comb
    begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        rd_en_next       = 1'b0;
        rd_sel_next      = STK_LEFT;
        rd_addr_next     = '0;
        wr_en_next       = 1'b0;
        wr_sel_next      = STK_LEFT;
        wr_addr_next     = '0;
        wr_from_key_next = 1'b0;
        read_valid_next  = 1'b0;
        ovf_next         = 1'b0;
        if (cmd == CMD_READ)
        begin
            read_valid_next = idx_x < len_x;
            rd_en_next      = read_valid_next;
            if (idx_x < XW'(left_count_reg))
            begin
                rd_sel_next  = STK_LEFT;
                rd_addr_next = idx_x[AW-1:0];
            end
            else
            begin
                rd_sel_next  = STK_RIGHT;
                rd_addr_next = rpos_x[AW-1:0];
            end
        end
        else
        begin
            unique case (key)
                KEY_BACKSPACE:
                begin
                    if (left_count_reg != '0)
                    begin
                        left_count_next = left_m1;
                    end
                end
                KEY_LEFT:
                begin
                    // move top of left stack onto right stack
                    if (left_count_reg != '0 && right_count_reg < CW'(CAPACITY))
                    begin
                        left_count_next  = left_m1;
                        right_count_next = right_count_reg + CW'(1);
                        rd_en_next       = 1'b1;
                        rd_sel_next      = STK_LEFT;
                        rd_addr_next     = left_m1[AW-1:0];
                        wr_en_next       = 1'b1;
                        wr_sel_next      = STK_RIGHT;
                        wr_addr_next     = right_count_reg[AW-1:0];
                    end
                end
                KEY_RIGHT:
                begin
                    if (right_count_reg != '0 && left_count_reg < CW'(CAPACITY))
                    begin
                        right_count_next = right_m1;
                        left_count_next  = left_count_reg + CW'(1);
                        rd_en_next       = 1'b1;
                        rd_sel_next      = STK_RIGHT;
                        rd_addr_next     = right_m1[AW-1:0];
                        wr_en_next       = 1'b1;
                        wr_sel_next      = STK_LEFT;
                        wr_addr_next     = left_count_reg[AW-1:0];
                    end
                end
                default:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        left_count_next  = left_count_reg + CW'(1);
                        wr_en_next       = 1'b1;
                        wr_sel_next      = STK_LEFT;
                        wr_addr_next     = left_count_reg[AW-1:0];
                        wr_from_key_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign len_after = XW'(left_count_next) + XW'(right_count_next);

    // Pending write lands at the same edge the next item reads: forward it.
    assign s1_adv       = !out_valid_reg || m_axis_tready;
    assign wr_fire      = s1_valid_reg && s1_adv && s1_wr_en_reg;
    assign fwd_hit_next = wr_fire && rd_en_next && (rd_sel_next == s1_wr_sel_reg)
                          && (rd_addr_next == s1_wr_addr_reg);

    assign s1_rd_data = s1_fwd_hit_reg ? s1_fwd_data_reg
                      : ((s1_rd_sel_reg == STK_LEFT) ? left_rd_data : right_rd_data);
    assign s1_wr_data = s1_wr_from_key_reg ? s1_key_reg : s1_rd_data;

    assign s_axis_tready  = !s1_valid_reg || s1_adv;
    assign s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    leb_stack_mem #(.DEPTH(CAPACITY)) u_left_stack
    (
        .clk     (clk),
        .wr_en   (wr_fire && (s1_wr_sel_reg == STK_LEFT)),
        .wr_addr (s1_wr_addr_reg),
        .wr_data (s1_wr_data),
        .rd_en   (in_accept && rd_en_next && (rd_sel_next == STK_LEFT)),
        .rd_addr (rd_addr_next),
        .rd_data (left_rd_data)
    );

    leb_stack_mem #(.DEPTH(CAPACITY)) u_right_stack
    (
        .clk     (clk),
        .wr_en   (wr_fire && (s1_wr_sel_reg == STK_RIGHT)),
        .wr_addr (s1_wr_addr_reg),
        .wr_data (s1_wr_data),
        .rd_en   (in_accept && rd_en_next && (rd_sel_next == STK_RIGHT)),
        .rd_addr (rd_addr_next),
        .rd_data (right_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                left_count_reg  <= left_count_next;
                right_count_reg <= right_count_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_rd_sel_reg      <= rd_sel_next;
            s1_fwd_hit_reg     <= fwd_hit_next;
            s1_fwd_data_reg    <= s1_wr_data;
            s1_wr_en_reg       <= wr_en_next;
            s1_wr_sel_reg      <= wr_sel_next;
            s1_wr_addr_reg     <= wr_addr_next;
            s1_wr_from_key_reg <= wr_from_key_next;
            s1_key_reg         <= key;
            s1_read_valid_reg  <= read_valid_next;
            s1_ovf_reg         <= ovf_next;
            s1_len_reg         <= CNT_OUT_W'(len_after);
            s1_cur_reg         <= CNT_OUT_W'(left_count_next);
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_char_reg   <= s1_read_valid_reg ? s1_rd_data : '0;
            out_rvalid_reg <= s1_read_valid_reg;
            out_len_reg    <= s1_len_reg;
            out_cur_reg    <= s1_cur_reg;
            out_ovf_reg    <= s1_ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rvalid_reg;
    assign m_axis_tdata  = {1'b0, out_ovf_reg, out_cur_reg, out_len_reg, out_char_reg};

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(left_count_reg) + XW'(right_count_reg)) <= XW'(CAPACITY))
        else $error("line length exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_KEY && key != KEY_BACKSPACE && key != KEY_LEFT
         && key != KEY_RIGHT && !full)
        |=> left_count_reg == $past(left_count_reg) + CW'(1))
        else $error("insert did not advance cursor");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in pipeline");

    a_read_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_read_valid_reg |-> !s1_ovf_reg && !s1_wr_en_reg)
        else $error("read item carries keystroke effects");
`endif

endmodule
